[hw/rtl/scaled_glyph_text_renderer_macros.svh]
// assertion macros shared by the text renderer rtl
`ifndef SCALED_GLYPH_TEXT_RENDERER_MACROS_SVH
`define SCALED_GLYPH_TEXT_RENDERER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SGTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SGTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sgtr_pkg.sv]
// shared types, constants and font table of the text renderer
`default_nettype none

package sgtr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 160;

  localparam int CURSOR_W = 16;
  localparam int STEP_W   = 7;
  localparam int LIMIT_W  = 11;
  localparam int POS_W    = 10;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7E;
  localparam logic [7:0] CHAR_QMARK   = 8'h3F;

  localparam logic [3:0] SCALE_MAX = 4'd8;
  localparam logic [2:0] COL_SPACE = 3'd5;
  localparam logic [2:0] ROW_LAST  = 3'd6;

  typedef struct packed {
    logic [CURSOR_W-1:0] a;
    logic [STEP_W-1:0]   b;
    logic [LIMIT_W-1:0]  limit;
  } sgtr_add_req_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] sum_sat;
    logic                fits;
  } sgtr_add_rsp_t;

  // column 0 in the low byte, bit r of a byte is row r from the top
  function automatic logic [39:0] pack5(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [7:0] c4);
    pack5 = {c4, c3, c2, c1, c0};
  endfunction

  // 5x7 font for codes 0x20..0x7e, index is code minus 0x20
  function automatic logic [39:0] glyph_bits(input logic [6:0] idx);
    case (idx)
      7'd0:  glyph_bits = pack5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd1:  glyph_bits = pack5(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
      7'd2:  glyph_bits = pack5(8'h00, 8'h07, 8'h00, 8'h07, 8'h00);
      7'd3:  glyph_bits = pack5(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14);
      7'd4:  glyph_bits = pack5(8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12);
      7'd5:  glyph_bits = pack5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      7'd6:  glyph_bits = pack5(8'h36, 8'h49, 8'h55, 8'h22, 8'h50);
      7'd7:  glyph_bits = pack5(8'h00, 8'h05, 8'h03, 8'h00, 8'h00);
      7'd8:  glyph_bits = pack5(8'h00, 8'h1C, 8'h22, 8'h41, 8'h00);
      7'd9:  glyph_bits = pack5(8'h00, 8'h41, 8'h22, 8'h1C, 8'h00);
      7'd10: glyph_bits = pack5(8'h14, 8'h08, 8'h3E, 8'h08, 8'h14);
      7'd11: glyph_bits = pack5(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
      7'd12: glyph_bits = pack5(8'h00, 8'h50, 8'h30, 8'h00, 8'h00);
      7'd13: glyph_bits = pack5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      7'd14: glyph_bits = pack5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      7'd15: glyph_bits = pack5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
      7'd16: glyph_bits = pack5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      7'd17: glyph_bits = pack5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      7'd18: glyph_bits = pack5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      7'd19: glyph_bits = pack5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      7'd20: glyph_bits = pack5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      7'd21: glyph_bits = pack5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      7'd22: glyph_bits = pack5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      7'd23: glyph_bits = pack5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      7'd24: glyph_bits = pack5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      7'd25: glyph_bits = pack5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      7'd26: glyph_bits = pack5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      7'd27: glyph_bits = pack5(8'h00, 8'h56, 8'h36, 8'h00, 8'h00);
      7'd28: glyph_bits = pack5(8'h08, 8'h14, 8'h22, 8'h41, 8'h00);
      7'd29: glyph_bits = pack5(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
      7'd30: glyph_bits = pack5(8'h00, 8'h41, 8'h22, 8'h14, 8'h08);
      7'd31: glyph_bits = pack5(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
      7'd32: glyph_bits = pack5(8'h32, 8'h49, 8'h79, 8'h41, 8'h3E);
      7'd33: glyph_bits = pack5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      7'd34: glyph_bits = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      7'd35: glyph_bits = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      7'd36: glyph_bits = pack5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      7'd37: glyph_bits = pack5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      7'd38: glyph_bits = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      7'd39: glyph_bits = pack5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      7'd40: glyph_bits = pack5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      7'd41: glyph_bits = pack5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      7'd42: glyph_bits = pack5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      7'd43: glyph_bits = pack5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      7'd44: glyph_bits = pack5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      7'd45: glyph_bits = pack5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      7'd46: glyph_bits = pack5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      7'd47: glyph_bits = pack5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      7'd48: glyph_bits = pack5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      7'd49: glyph_bits = pack5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      7'd50: glyph_bits = pack5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      7'd51: glyph_bits = pack5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      7'd52: glyph_bits = pack5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      7'd53: glyph_bits = pack5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      7'd54: glyph_bits = pack5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      7'd55: glyph_bits = pack5(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
      7'd56: glyph_bits = pack5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      7'd57: glyph_bits = pack5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      7'd58: glyph_bits = pack5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      7'd59: glyph_bits = pack5(8'h00, 8'h7F, 8'h41, 8'h41, 8'h00);
      7'd60: glyph_bits = pack5(8'h02, 8'h04, 8'h08, 8'h10, 8'h20);
      7'd61: glyph_bits = pack5(8'h00, 8'h41, 8'h41, 8'h7F, 8'h00);
      7'd62: glyph_bits = pack5(8'h04, 8'h02, 8'h01, 8'h02, 8'h04);
      7'd63: glyph_bits = pack5(8'h40, 8'h40, 8'h40, 8'h40, 8'h40);
      7'd64: glyph_bits = pack5(8'h00, 8'h01, 8'h02, 8'h04, 8'h00);
      7'd65: glyph_bits = pack5(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
      7'd66: glyph_bits = pack5(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
      7'd67: glyph_bits = pack5(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
      7'd68: glyph_bits = pack5(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
      7'd69: glyph_bits = pack5(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
      7'd70: glyph_bits = pack5(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
      7'd71: glyph_bits = pack5(8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E);
      7'd72: glyph_bits = pack5(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
      7'd73: glyph_bits = pack5(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
      7'd74: glyph_bits = pack5(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00);
      7'd75: glyph_bits = pack5(8'h7F, 8'h10, 8'h28, 8'h44, 8'h00);
      7'd76: glyph_bits = pack5(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
      7'd77: glyph_bits = pack5(8'h7C, 8'h04, 8'h18, 8'h04, 8'h78);
      7'd78: glyph_bits = pack5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
      7'd79: glyph_bits = pack5(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
      7'd80: glyph_bits = pack5(8'h7C, 8'h14, 8'h14, 8'h14, 8'h08);
      7'd81: glyph_bits = pack5(8'h08, 8'h14, 8'h14, 8'h18, 8'h7C);
      7'd82: glyph_bits = pack5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
      7'd83: glyph_bits = pack5(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
      7'd84: glyph_bits = pack5(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20);
      7'd85: glyph_bits = pack5(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
      7'd86: glyph_bits = pack5(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
      7'd87: glyph_bits = pack5(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
      7'd88: glyph_bits = pack5(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
      7'd89: glyph_bits = pack5(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C);
      7'd90: glyph_bits = pack5(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
      7'd91: glyph_bits = pack5(8'h00, 8'h08, 8'h36, 8'h41, 8'h00);
      7'd92: glyph_bits = pack5(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);
      7'd93: glyph_bits = pack5(8'h00, 8'h41, 8'h36, 8'h08, 8'h00);
      7'd94: glyph_bits = pack5(8'h08, 8'h08, 8'h2A, 8'h1C, 8'h08);
      default: glyph_bits = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sgtr_add_unit.sv]
// shared saturating adder with screen-limit compare
`default_nettype none

module sgtr_add_unit (
  input  wire sgtr_pkg::sgtr_add_req_t req,
  output sgtr_pkg::sgtr_add_rsp_t      rsp
);

  logic [sgtr_pkg::CURSOR_W:0] sum;

  assign sum = {1'b0, req.a} + (sgtr_pkg::CURSOR_W + 1)'(req.b);

  // saturate at all ones instead of wrapping
  assign rsp.sum_sat = sum[sgtr_pkg::CURSOR_W] ? '1 : sum[sgtr_pkg::CURSOR_W-1:0];
  assign rsp.fits    = sum <= (sgtr_pkg::CURSOR_W + 1)'(req.limit);

endmodule

`default_nettype wire

[hw/rtl/scaled_glyph_text_renderer.sv]
// top level of the scaled 5x7 text renderer
`default_nettype none
`include "scaled_glyph_text_renderer_macros.svh"

// Scaled text renderer: takes one character request at a time and turns it into
// filled-rectangle requests for a pixel engine. in_tuser set puts the cursor at
// the origin carried with the character; newline (0x0a) returns the cursor to
// origin x and moves it down 8*scale; other codes outside 0x20..0x7e draw '?'.
// When the panel is enabled (cfg_wr_data written high) and the glyph fits
// wholly on screen, 35 cells of scale x scale come out column by column, top
// row first, then one background spacing column of scale x 7*scale marked with
// out_tlast. The cursor then moves right by 6*scale and saturates at 0xffff.
// Scale above eight acts as eight; scale zero draws nothing and does not step
// the cursor right. in_tready is high only while the block is idle. A drawn
// character passes through setup, two fit checks, 36 rectangles at one per
// cycle while out_tready is high, one cursor update and a return to idle; a
// character that is not drawn skips the rectangles and a newline ends after
// setup. The single shared adder steps the cell position, does the fit checks
// and moves the cursor, one operation per cycle. A rectangle that waits on
// out_tready holds the walk; the output register is refilled in the cycle its
// rectangle is taken, so a ready receiver sees one rectangle per cycle.

module scaled_glyph_text_renderer #(
  parameter int SCREEN_WIDTH  = sgtr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = sgtr_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire         cfg_wr_data,    // display_enabled
  input  wire         in_tvalid,
  output logic        in_tready,
  // char_code[7:0], origin_x[18:8], origin_y[29:19], fg_color[45:30],
  // bg_color[61:46], scale[65:62], zero pad[71:66]
  input  wire  [71:0] in_tdata,
  input  wire         in_tuser,       // start_of_string
  output logic        out_tvalid,
  input  wire         out_tready,
  // rect_x[9:0], rect_y[19:10], rect_width[23:20], rect_height[29:24],
  // rect_color[45:30], zero pad[47:46]
  output logic [47:0] out_tdata,
  output logic        out_tlast       // last
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SETUP   = 6'b000010,
    ST_CHECK_X = 6'b000100,
    ST_CHECK_Y = 6'b001000,
    ST_EMIT    = 6'b010000,
    ST_ADVANCE = 6'b100000
  } state_t;

  localparam int CW = sgtr_pkg::CURSOR_W;
  localparam int PW = sgtr_pkg::POS_W;
  localparam int SW = sgtr_pkg::STEP_W;

  localparam logic [sgtr_pkg::LIMIT_W-1:0] LIMIT_X = sgtr_pkg::LIMIT_W'(SCREEN_WIDTH);
  localparam logic [sgtr_pkg::LIMIT_W-1:0] LIMIT_Y = sgtr_pkg::LIMIT_W'(SCREEN_HEIGHT);

  state_t state_r, state_nxt;

  logic          enabled_r;
  logic [CW-1:0] cursor_x_r, cursor_x_nxt;
  logic [CW-1:0] cursor_y_r, cursor_y_nxt;

  // latched request
  logic [7:0]  code_r;
  logic        start_r;
  logic [10:0] origin_x_r;
  logic [10:0] origin_y_r;
  logic [15:0] fg_r;
  logic [15:0] bg_r;
  logic [3:0]  scale_r;
  logic        fit_x_r, fit_x_nxt;

  // glyph walk
  logic [39:0]   glyph_r, glyph_nxt;
  logic [2:0]    col_r, col_nxt;
  logic [2:0]    row_r, row_nxt;
  logic [PW-1:0] pos_x_r, pos_x_nxt;
  logic [PW-1:0] pos_y_r, pos_y_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_x_r, out_x_nxt;
  logic [PW-1:0] out_y_r, out_y_nxt;
  logic [3:0]    out_w_r, out_w_nxt;
  logic [5:0]    out_h_r, out_h_nxt;
  logic [15:0]   out_color_r, out_color_nxt;
  logic          out_last_r, out_last_nxt;

  logic [3:0]    scale_in;
  logic          in_accept;
  logic          out_free;
  logic          printable;
  logic [6:0]    glyph_idx;
  logic [CW-1:0] base_x, base_y;
  logic [SW-1:0] step6, step8;
  logic [5:0]    height7;

  sgtr_pkg::sgtr_add_req_t add_req;
  sgtr_pkg::sgtr_add_rsp_t add_rsp;

  sgtr_add_unit u_add (
    .req (add_req),
    .rsp (add_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_color_r, out_h_r, out_w_r, out_y_r, out_x_r};

  // scale clamp on the way in
  assign scale_in = (in_tdata[65:62] > sgtr_pkg::SCALE_MAX) ? sgtr_pkg::SCALE_MAX
                                                             : in_tdata[65:62];

  // multiples of scale are shifts, one narrow add and one narrow subtract
  assign step6   = SW'({scale_r, 2'b00}) + SW'({scale_r, 1'b0});
  assign step8   = SW'({scale_r, 3'b000});
  assign height7 = 6'(SW'({scale_r, 3'b000}) - SW'(scale_r));

  assign printable = (code_r >= sgtr_pkg::CHAR_FIRST) && (code_r <= sgtr_pkg::CHAR_LAST);
  assign glyph_idx = printable ? 7'(code_r - sgtr_pkg::CHAR_FIRST)
                               : 7'(sgtr_pkg::CHAR_QMARK - sgtr_pkg::CHAR_FIRST);

  // cursor after the start flag is applied
  assign base_x = start_r ? CW'(origin_x_r) : cursor_x_r;
  assign base_y = start_r ? CW'(origin_y_r) : cursor_y_r;

  // operand select for the shared adder, one operation per state
  always_comb begin
    add_req.a     = base_y;
    add_req.b     = step8;
    add_req.limit = LIMIT_Y;
    unique case (state_r)
      ST_IDLE, ST_SETUP: begin
        // newline step down
        add_req.a = base_y;
        add_req.b = step8;
      end
      ST_CHECK_X: begin
        add_req.a     = cursor_x_r;
        add_req.b     = step6;
        add_req.limit = LIMIT_X;
      end
      ST_CHECK_Y: begin
        add_req.a = cursor_y_r;
        add_req.b = step8;
      end
      ST_EMIT: begin
        // bottom row steps x to the next column, otherwise y steps down
        add_req.a = (row_r == sgtr_pkg::ROW_LAST) ? CW'(pos_x_r) : CW'(pos_y_r);
        add_req.b = SW'(scale_r);
      end
      ST_ADVANCE: begin
        add_req.a = cursor_x_r;
        add_req.b = step6;
      end
      default: begin
        add_req.a = base_y;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    fit_x_nxt     = fit_x_r;
    glyph_nxt     = glyph_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_w_nxt     = out_w_r;
    out_h_nxt     = out_h_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (code_r == sgtr_pkg::CHAR_NEWLINE) begin
          cursor_x_nxt = CW'(origin_x_r);
          cursor_y_nxt = add_rsp.sum_sat;
          state_nxt    = ST_IDLE;
        end else begin
          cursor_x_nxt = base_x;
          cursor_y_nxt = base_y;
          glyph_nxt    = sgtr_pkg::glyph_bits(glyph_idx);
          state_nxt    = ST_CHECK_X;
        end
      end
      ST_CHECK_X: begin
        fit_x_nxt = add_rsp.fits;
        state_nxt = ST_CHECK_Y;
      end
      ST_CHECK_Y: begin
        col_nxt   = '0;
        row_nxt   = '0;
        pos_x_nxt = cursor_x_r[PW-1:0];
        pos_y_nxt = cursor_y_r[PW-1:0];
        if (enabled_r && (scale_r != 4'd0) && fit_x_r && add_rsp.fits) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pos_x_r;
          out_w_nxt     = scale_r;
          if (col_r == sgtr_pkg::COL_SPACE) begin
            // spacing column closes the character
            out_y_nxt     = cursor_y_r[PW-1:0];
            out_h_nxt     = height7;
            out_color_nxt = bg_r;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_ADVANCE;
          end else begin
            out_y_nxt     = pos_y_r;
            out_h_nxt     = 6'(scale_r);
            out_color_nxt = glyph_r[{col_r, row_r}] ? fg_r : bg_r;
            out_last_nxt  = 1'b0;
            if (row_r == sgtr_pkg::ROW_LAST) begin
              row_nxt   = '0;
              col_nxt   = col_r + 3'd1;
              pos_x_nxt = add_rsp.sum_sat[PW-1:0];
              pos_y_nxt = cursor_y_r[PW-1:0];
            end else begin
              row_nxt   = row_r + 3'd1;
              pos_y_nxt = add_rsp.sum_sat[PW-1:0];
            end
          end
        end
      end
      ST_ADVANCE: begin
        cursor_x_nxt = add_rsp.sum_sat;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enabled_r   <= 1'b0;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      code_r     <= in_tdata[7:0];
      origin_x_r <= in_tdata[18:8];
      origin_y_r <= in_tdata[29:19];
      fg_r       <= in_tdata[45:30];
      bg_r       <= in_tdata[61:46];
      scale_r    <= scale_in;
      start_r    <= in_tuser;
    end
    fit_x_r     <= fit_x_nxt;
    glyph_r     <= glyph_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    pos_x_r     <= pos_x_nxt;
    pos_y_r     <= pos_y_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_w_r     <= out_w_nxt;
    out_h_r     <= out_h_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  `SGTR_ASSERT_NEXT(a_accept_to_setup, in_accept, state_r == ST_SETUP, "request not taken into setup")
  `SGTR_ASSERT_NOW(a_walk_in_range, state_r == ST_EMIT, (col_r <= sgtr_pkg::COL_SPACE) && (row_r <= sgtr_pkg::ROW_LAST), "glyph walk out of range")
  `SGTR_ASSERT_NOW(a_cell_square, out_valid_r && !out_last_r, out_h_r == 6'(out_w_r), "cell rectangle not square")
  `SGTR_ASSERT_NOW(a_space_height, out_valid_r && out_last_r, out_h_r == 6'(SW'({out_w_r, 3'b000}) - SW'(out_w_r)), "spacing column height not seven cells")

endmodule

`default_nettype wire
